### rtl/utf8_to_utf16_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder assertion macros
// Shared assertion shorthands for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_STREAM_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8U16_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Byte classes, the item bundle passed from front to back, and defaults.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam logic [7:0] CONT_LO  = 8'h80;
	localparam logic [7:0] CONT_HI  = 8'hBF;
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;

	localparam int unsigned MAX_UNITS         = 3;
	localparam int unsigned QUEUE_DEPTH_DEF   = 4;

	typedef struct packed {
		logic [MAX_UNITS-1:0][15:0] units;
		logic [1:0]                 count;
		logic                       eos;
	} bundle_t;

	function automatic logic is_cont(input logic [7:0] b);
		return b inside {[CONT_LO:CONT_HI]};
	endfunction

	function automatic logic is_lead2(input logic [7:0] b);
		return b inside {[LEAD2_LO:LEAD2_HI]};
	endfunction

	function automatic logic is_lead3(input logic [7:0] b);
		return b inside {[LEAD3_LO:LEAD3_HI]};
	endfunction

endpackage

### rtl/u8u16_front.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder front end
// Accepts bytes, tracks the pending sequence and builds the code units of
// each item as one bundle for the queue.
// ----------------------------------------------------------------------------
module u8u16_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_eos,
	output logic                push,
	output u8u16_pkg::bundle_t  push_data,
	input  logic                queue_full
);
	import u8u16_pkg::*;

	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_LEAD = 2'd1,
		HELD_TWO  = 2'd2
	} held_t;

	held_t       held_count_q;
	logic [7:0]  held_lead_q;
	logic [7:0]  held_cont_q;

	held_t       nxt_count;
	logic [7:0]  nxt_lead;
	logic [7:0]  nxt_cont;
	logic [3:0][15:0] units;
	logic [1:0]  n;
	logic        fresh;
	logic        accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		n         = 2'd0;
		units     = '0;
		fresh     = 1'b0;
		nxt_count = held_count_q;
		nxt_lead  = held_lead_q;
		nxt_cont  = held_cont_q;
		case (held_count_q)
			HELD_LEAD: begin
				if (is_cont(in_byte) && is_lead2(held_lead_q)) begin
					units[0]  = {5'd0, held_lead_q[4:0], in_byte[5:0]};
					n         = 2'd1;
					nxt_count = HELD_NONE;
				end else if (is_cont(in_byte) && is_lead3(held_lead_q)) begin
					nxt_cont  = in_byte;
					nxt_count = HELD_TWO;
				end else begin
					units[0] = {8'd0, held_lead_q};
					n        = 2'd1;
					fresh    = 1'b1;
				end
			end
			HELD_TWO: begin
				if (is_cont(in_byte)) begin
					units[0]  = {held_lead_q[3:0], held_cont_q[5:0], in_byte[5:0]};
					n         = 2'd1;
					nxt_count = HELD_NONE;
				end else begin
					units[0] = {8'd0, held_lead_q};
					units[1] = {8'd0, held_cont_q};
					n        = 2'd2;
					fresh    = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (is_lead2(in_byte) || is_lead3(in_byte)) begin
				nxt_lead  = in_byte;
				nxt_count = HELD_LEAD;
			end else begin
				units[n]  = {8'd0, in_byte};
				n         = n + 2'd1;
				nxt_count = HELD_NONE;
			end
		end
		if (in_eos) begin
			if (nxt_count == HELD_LEAD || nxt_count == HELD_TWO) begin
				units[n] = {8'd0, nxt_lead};
				n        = n + 2'd1;
			end
			if (nxt_count == HELD_TWO) begin
				units[n] = {8'd0, nxt_cont};
				n        = n + 2'd1;
			end
			nxt_count = HELD_NONE;
		end
		if (nxt_count == HELD_NONE) begin
			nxt_lead = 8'd0;
			nxt_cont = 8'd0;
		end
	end

	assign push            = accept && (n != 2'd0);
	assign push_data.units = units[MAX_UNITS-1:0];
	assign push_data.count = n;
	assign push_data.eos   = in_eos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= HELD_NONE;
			held_lead_q  <= 8'd0;
			held_cont_q  <= 8'd0;
		end else if (accept) begin
			held_count_q <= nxt_count;
			held_lead_q  <= nxt_lead;
			held_cont_q  <= nxt_cont;
		end
	end

endmodule

### rtl/u8u16_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder bundle queue
// Short first-in first-out queue of bundles between front and back end.
// ----------------------------------------------------------------------------
module u8u16_queue #(
	parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8u16_pkg::bundle_t  push_data,
	output logic                full,
	input  logic                pop,
	output u8u16_pkg::bundle_t  head,
	output logic                head_valid
);
	import u8u16_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/u8u16_back.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder back end
// Walks the code units of the head bundle into the output register,
// one per cycle unless stalled, and marks the end of each run and string.
// ----------------------------------------------------------------------------
module u8u16_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u8u16_pkg::bundle_t  head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         out_unit,
	output logic                out_last,
	output logic                out_end
);
	import u8u16_pkg::*;

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [15:0] out_unit_q;
	logic        out_last_q;
	logic        out_end_q;
	logic        load;
	logic        take;
	logic        is_last;

	assign load    = !out_valid_q || out_ready;
	assign take    = head_valid && load;
	assign is_last = (idx_q == head.count - 2'd1);
	assign pop     = take && is_last;

	always_ff @(posedge clk) begin
		if (take) begin
			out_unit_q <= head.units[idx_q];
			out_last_q <= is_last;
			out_end_q  <= is_last && head.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_unit  = out_unit_q;
	assign out_last  = out_last_q;
	assign out_end   = out_end_q;

endmodule

### rtl/utf8_to_utf16_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder
// Decodes one-, two- and three-byte UTF-8 forms to 16-bit code units;
// bytes outside a complete valid form pass through raw.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata               tuser       tlast
// s_axis    in         [7:0] in_byte       -           end_of_string
// m_axis    out        [15:0] code_unit    [0] string_end  last_of_run
//
// The front end takes one byte per cycle while the queue has room.
// The back end sends one code unit per cycle while the output is ready, and a
// byte produces zero to three code units.
// A code unit reaches the output through the queue and the output register.
// A full queue holds the input off, and a stalled output holds the back end.
// Reset clears the held sequence, the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] code_unit
	output logic [0:0]  m_axis_tuser,   // [0] string_end
	output logic        m_axis_tlast
);
	import u8u16_pkg::*;

	bundle_t push_data;
	bundle_t head;
	logic    push;
	logic    full;
	logic    pop;
	logic    head_valid;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_eos     (s_axis_tlast),
		.push       (push),
		.push_data  (push_data),
		.queue_full (full)
	);

	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_unit   (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_end    (m_axis_tuser[0])
	);

endmodule

### rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder port checker
// Watches the decoder's output ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_stream_decoder_macros.svh"

module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A string end always closes the run of its item.
	`U8U16_ASSERT_SAME(a_end_is_last, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "string end without last of run")

	// Only the last code unit of a run can be a decoded one; earlier ones are raw bytes.
	`U8U16_ASSERT_SAME(a_early_raw, clk, arst_n,
		m_axis_tvalid && !m_axis_tlast, m_axis_tdata[15:8] == 8'd0,
		"decoded unit before end of run")

	`U8U16_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"stalled item changed")

	`U8U16_ASSERT_NEXT(a_out_stay, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tuser), "stalled item flag changed")

endmodule

bind utf8_to_utf16_stream_decoder u8u16_checker u_chk (.*);

### bench/utf8_to_utf16_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder testbench
// Feeds UTF-8 bytes with an end-of-string flag and checks every code unit
// against a cycle-free model of the decoder kept in this bench, or against
// the units of a fixed directed row. A directed table covers boundary bytes
// and broken and truncated forms; random strings with mostly well-formed
// characters follow. Both sides stall at random outside one stretch.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_tb;
	import u8u16_pkg::*;

	localparam int RANDOM_BYTES = 100;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [15:0] unit;
		logic        last_of_run;
		logic        string_end;
	} utf16_unit_t;

	typedef struct packed {
		logic [7:0]  in_byte;
		logic        eos;
		logic        fixed;
		logic [1:0]  n;
		logic [15:0] u0;
		logic [15:0] u1;
		logic [15:0] u2;
	} stim_row_t;

	localparam int N_DIRECTED = 28;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h41, 1'b0, 1'b1, 2'd1, 16'h0041, 16'h0000, 16'h0000},
		'{8'h00, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h0000},
		'{8'hFF, 1'b0, 1'b1, 2'd1, 16'h00FF, 16'h0000, 16'h0000},
		'{8'h80, 1'b0, 1'b1, 2'd1, 16'h0080, 16'h0000, 16'h0000},
		'{8'hC2, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'h80, 1'b0, 1'b1, 2'd1, 16'h0080, 16'h0000, 16'h0000},
		'{8'hDF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 1'b1, 2'd1, 16'h07FF, 16'h0000, 16'h0000},
		'{8'hC3, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hE0, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'h80, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h0000},
		'{8'hEF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hBF, 1'b1, 1'b1, 2'd1, 16'hFFFF, 16'h0000, 16'h0000},
		'{8'hE4, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hB8, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hAD, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hC1, 1'b0, 1'b1, 2'd1, 16'h00C1, 16'h0000, 16'h0000},
		'{8'hF0, 1'b0, 1'b1, 2'd1, 16'h00F0, 16'h0000, 16'h0000},
		'{8'hC2, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'h41, 1'b0, 1'b1, 2'd2, 16'h00C2, 16'h0041, 16'h0000},
		'{8'hE5, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hA0, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
		'{8'hE1, 1'b0, 1'b1, 2'd2, 16'h00E5, 16'h00A0, 16'h0000},
		'{8'h7F, 1'b1, 1'b1, 2'd2, 16'h00E1, 16'h007F, 16'h0000},
		'{8'hE2, 1'b1, 1'b1, 2'd1, 16'h00E2, 16'h0000, 16'h0000}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;

	utf16_unit_t expected_units[$];
	utf16_unit_t step_units[$];
	logic [7:0]  str_bytes[$];

	logic [7:0]  lead_byte;
	logic [7:0]  first_cont;
	logic [1:0]  pend_cnt;

	bit          row_fixed;
	stim_row_t   row_ref;
	bit          gaps_on;
	int          errors;
	int          idle_cycles;

	utf8_to_utf16_stream_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic is_cont_byte(input logic [7:0] b);
		return b >= CONT_LO && b <= CONT_HI;
	endfunction

	function automatic logic is_two_lead(input logic [7:0] b);
		return b >= LEAD2_LO && b <= LEAD2_HI;
	endfunction

	function automatic logic is_three_lead(input logic [7:0] b);
		return b >= LEAD3_LO && b <= LEAD3_HI;
	endfunction

	task automatic emit_unit(input logic [15:0] u);
		step_units.push_back('{unit: u, last_of_run: 1'b0, string_end: 1'b0});
	endtask

	task automatic open_sequence(input logic [7:0] b);
		if (is_two_lead(b) || is_three_lead(b)) begin
			lead_byte = b;
			pend_cnt  = 2'd1;
		end else begin
			pend_cnt = 2'd0;
			emit_unit({8'h00, b});
		end
	endtask

	// Works out the code units caused by one byte and advances the held state.
	task automatic decode_byte(input logic [7:0] b, input logic eos);
		utf16_unit_t tail;
		step_units.delete();
		case (pend_cnt)
			2'd1: begin
				if (is_cont_byte(b) && is_two_lead(lead_byte)) begin
					emit_unit({5'b0, lead_byte[4:0], b[5:0]});
					pend_cnt = 2'd0;
				end else if (is_cont_byte(b) && is_three_lead(lead_byte)) begin
					first_cont = b;
					pend_cnt   = 2'd2;
				end else begin
					emit_unit({8'h00, lead_byte});
					open_sequence(b);
				end
			end
			2'd2: begin
				if (is_cont_byte(b)) begin
					emit_unit({lead_byte[3:0], first_cont[5:0], b[5:0]});
					pend_cnt = 2'd0;
				end else begin
					emit_unit({8'h00, lead_byte});
					emit_unit({8'h00, first_cont});
					open_sequence(b);
				end
			end
			default: begin
				open_sequence(b);
			end
		endcase
		if (eos) begin
			if (pend_cnt == 2'd1 || pend_cnt == 2'd2)
				emit_unit({8'h00, lead_byte});
			if (pend_cnt == 2'd2)
				emit_unit({8'h00, first_cont});
			pend_cnt = 2'd0;
		end
		if (pend_cnt == 2'd0) begin
			lead_byte  = 8'h00;
			first_cont = 8'h00;
		end
		if (step_units.size() > 0) begin
			tail             = step_units.pop_back();
			tail.last_of_run = 1'b1;
			tail.string_end  = eos;
			step_units.push_back(tail);
		end
	endtask

	always @(posedge clk) begin : monitor
		utf16_unit_t got;
		utf16_unit_t want;
		logic [15:0] fixed_unit;
		if (!arst_n) begin
			lead_byte  = 8'h00;
			first_cont = 8'h00;
			pend_cnt   = 2'd0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{unit: m_axis_tdata, last_of_run: m_axis_tlast,
					string_end: m_axis_tuser[0]};
				if (expected_units.size() == 0) begin
					$display("%0t: unexpected code unit %h last %b end %b", $time,
						got.unit, got.last_of_run, got.string_end);
					errors++;
				end else begin
					want = expected_units.pop_front();
					if (got.unit !== want.unit || got.last_of_run !== want.last_of_run
							|| got.string_end !== want.string_end) begin
						$display("%0t: expected unit %h last %b end %b, got unit %h last %b end %b",
							$time, want.unit, want.last_of_run, want.string_end,
							got.unit, got.last_of_run, got.string_end);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
				if (row_fixed) begin
					step_units.delete();
					for (int k = 0; k < row_ref.n; k++) begin
						fixed_unit = (k == 0) ? row_ref.u0 : (k == 1) ? row_ref.u1 : row_ref.u2;
						step_units.push_back('{unit: fixed_unit,
							last_of_run: (k == row_ref.n - 1),
							string_end: (k == row_ref.n - 1) && row_ref.eos});
					end
				end
				foreach (step_units[k])
					expected_units.push_back(step_units[k]);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= gaps_on ? ($urandom_range(99) >= 33) : 1'b1;
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		while (gaps_on && $urandom_range(99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random string of mostly well-formed characters, now and then noise, a
	// broken form or a truncated tail.
	task automatic build_string();
		int nchar;
		int kind;
		int cut;
		str_bytes.delete();
		nchar = $urandom_range(6, 1);
		repeat (nchar) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				str_bytes.push_back(8'($urandom_range(8'h7F)));
			end else if (kind < 60) begin
				str_bytes.push_back(8'($urandom_range(LEAD2_HI, LEAD2_LO)));
				str_bytes.push_back(8'($urandom_range(CONT_HI, CONT_LO)));
			end else if (kind < 85) begin
				str_bytes.push_back(8'($urandom_range(LEAD3_HI, LEAD3_LO)));
				str_bytes.push_back(8'($urandom_range(CONT_HI, CONT_LO)));
				str_bytes.push_back(8'($urandom_range(CONT_HI, CONT_LO)));
			end else if (kind < 93) begin
				str_bytes.push_back(8'($urandom_range(8'hFF)));
			end else begin
				str_bytes.push_back(8'($urandom_range(LEAD3_HI, LEAD2_LO)));
				if ($urandom_range(1))
					str_bytes.push_back(8'($urandom_range(CONT_HI, CONT_LO)));
				str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h7F))
					: 8'($urandom_range(8'hFF, 8'hC0)));
			end
		end
		if (str_bytes.size() > 2 && $urandom_range(99) < 20) begin
			cut = $urandom_range(2, 1);
			repeat (cut)
				void'(str_bytes.pop_back());
		end
	endtask

	initial begin
		int sent;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		row_fixed     = 1'b0;
		row_ref       = '0;
		gaps_on       = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row_fixed = DIRECTED[i].fixed;
			row_ref   = DIRECTED[i];
			send_byte(DIRECTED[i].in_byte, DIRECTED[i].eos);
		end
		row_fixed = 1'b0;

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			gaps_on = !(sent >= 50 && sent < 90);
			build_string();
			foreach (str_bytes[k]) begin
				send_byte(str_bytes[k], k == str_bytes.size() - 1);
				sent++;
			end
		end
		gaps_on       = 1'b1;
		s_axis_tvalid <= 1'b0;

		while (expected_units.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && expected_units.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
